// ===== rtl/pfi_pkg.sv =====
// ----------------------------------------------------------------------------
// Phase-field point update package
// Shared fixed-point types, constants, register indexes and arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pfi_pkg;

    // Number of fraction bits in every value.
    localparam int FRAC_BITS = 24;

    // Width of the dividend in the quotient unit, one stage per bit.
    localparam int DIV_AW = 32 + FRAC_BITS;

    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_wide;
    typedef logic [7:0]         t_cfg_idx;

    // A value together with its saturation flag.
    typedef struct packed {
        logic s;
        t_q   v;
    } t_qval;

    // Values that travel alongside the quotient unit.
    typedef struct packed {
        logic sat;
        t_q   pnext;
        t_q   mu;
    } t_side;

    localparam t_wide MAX_W   = 64'sh0000_0000_7FFF_FFFF;
    localparam t_wide MIN_W   = 64'shFFFF_FFFF_8000_0000;
    localparam t_wide ONE_W   = 64'sd1 <<< FRAC_BITS;
    localparam t_wide THREE_W = ONE_W * 64'sd3;

    // Reset value for the coefficients that default to one.
    localparam t_q CFG_ONE_RST = (FRAC_BITS >= 31) ? 32'sh7FFF_FFFF : t_q'(ONE_W[31:0]);
    localparam t_q CFG_DT_RST  = 32'sd16777;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_GE_PRODUCT     = 8'd0;
    localparam t_cfg_idx CFG_G_OVER_E       = 8'd1;
    localparam t_cfg_idx CFG_INV_TAU_E      = 8'd2;
    localparam t_cfg_idx CFG_K_MINUS_ONE    = 8'd3;
    localparam t_cfg_idx CFG_MU_EQUILIBRIUM = 8'd4;
    localparam t_cfg_idx CFG_TIME_STEP      = 8'd5;
    localparam t_cfg_idx CFG_MOBILITY       = 8'd6;
    localparam t_cfg_idx CFG_INV_SPACING    = 8'd7;

    // Clamp a wide value to 32 bits and report whether it was clamped.
    function automatic t_qval sat32(input t_wide x);
        t_qval r;
        if (x > MAX_W) begin
            r.s = 1'b1;
            r.v = 32'sh7FFF_FFFF;
        end else if (x < MIN_W) begin
            r.s = 1'b1;
            r.v = 32'sh8000_0000;
        end else begin
            r.s = 1'b0;
            r.v = x[31:0];
        end
        return r;
    endfunction

    // Fixed-point product, floored and saturated.
    function automatic t_qval qmul(input t_q a, input t_q b);
        t_wide prod;
        prod = t_wide'(a) * t_wide'(b);
        return sat32(prod >>> FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pfi_div.sv =====
// ----------------------------------------------------------------------------
// Phase-field quotient unit
// Pipelined restoring divider, one quotient bit per stage, giving the
// saturated fixed-point quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pfi_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire pfi_pkg::t_q     i_num,
    input  wire pfi_pkg::t_q     i_den,
    input  wire pfi_pkg::t_side  i_side,
    output logic                 o_valid,
    output pfi_pkg::t_qval       o_incr,
    output pfi_pkg::t_side       o_side
);
    import pfi_pkg::*;

    localparam int AW = DIV_AW;

    typedef struct packed {
        logic neg;
        logic dz;
        logic npos;
        logic nneg;
    } t_dctl;

    logic            r_v    [0:AW];
    logic [31:0]     r_rem  [0:AW];
    logic [AW-1:0]   r_d    [0:AW];
    logic [32:0]     r_qt   [0:AW];
    logic            r_big  [0:AW];
    logic [31:0]     r_b    [0:AW];
    t_dctl           r_ctl  [0:AW];
    t_side           r_sd   [0:AW];

    logic [31:0]     n_rem  [1:AW];
    logic [32:0]     n_qt   [1:AW];

    logic [31:0]     n_a;
    logic [31:0]     n_b;
    t_dctl           n_ctl;
    t_qval           n_res;

    logic            r_fin_v;
    t_qval           r_fin;
    t_side           r_fin_sd;

    // Magnitudes and sign handling at the entry.
    always_comb begin
        n_a       = i_num[31] ? (~i_num + 32'd1) : i_num;
        n_b       = i_den[31] ? (~i_den + 32'd1) : i_den;
        n_ctl.neg = i_num[31] ^ i_den[31];
        n_ctl.dz  = (i_den == 32'sd0);
        n_ctl.npos = (i_num > 32'sd0);
        n_ctl.nneg = i_num[31];
    end

    // One restoring step per stage.
    always_comb begin
        logic [32:0] sh;
        logic [32:0] diff;
        logic        ge;
        sh   = '0;
        diff = '0;
        ge   = 1'b0;
        for (int k = 1; k <= AW; k++) begin
            sh       = {r_rem[k-1], r_d[k-1][AW-1]};
            diff     = sh - {1'b0, r_b[k-1]};
            ge       = (sh >= {1'b0, r_b[k-1]});
            n_rem[k] = ge ? diff[31:0] : sh[31:0];
            n_qt[k]  = {r_qt[k-1][31:0], ge};
        end
    end

    // Clamp the magnitude and apply the sign.
    always_comb begin
        logic [33:0] mag;
        if (r_big[AW] || (r_qt[AW] > 33'h0_8000_0000)) begin
            mag = 34'h0_8000_0001;
        end else begin
            mag = {1'b0, r_qt[AW]};
        end
        if (r_ctl[AW].dz) begin
            n_res.s = 1'b1;
            if (r_ctl[AW].npos) begin
                n_res.v = 32'sh7FFF_FFFF;
            end else if (r_ctl[AW].nneg) begin
                n_res.v = 32'sh8000_0000;
            end else begin
                n_res.v = 32'sd0;
            end
        end else if (r_ctl[AW].neg) begin
            if (mag > 34'h0_8000_0000) begin
                n_res.s = 1'b1;
                n_res.v = 32'sh8000_0000;
            end else begin
                n_res.s = 1'b0;
                n_res.v = ~mag[31:0] + 32'd1;
            end
        end else begin
            if (mag > 34'h0_7FFF_FFFF) begin
                n_res.s = 1'b1;
                n_res.v = 32'sh7FFF_FFFF;
            end else begin
                n_res.s = 1'b0;
                n_res.v = mag[31:0];
            end
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= AW; k++) begin
                r_v[k] <= 1'b0;
            end
            r_fin_v <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= AW; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_fin_v <= r_v[AW];
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_d[0]   <= {n_a, {FRAC_BITS{1'b0}}};
            r_qt[0]  <= '0;
            r_big[0] <= 1'b0;
            r_b[0]   <= n_b;
            r_ctl[0] <= n_ctl;
            r_sd[0]  <= i_side;
            for (int k = 1; k <= AW; k++) begin
                r_rem[k] <= n_rem[k];
                r_d[k]   <= r_d[k-1] << 1;
                r_qt[k]  <= n_qt[k];
                r_big[k] <= r_big[k-1] | r_qt[k-1][32];
                r_b[k]   <= r_b[k-1];
                r_ctl[k] <= r_ctl[k-1];
                r_sd[k]  <= r_sd[k-1];
            end
            r_fin    <= n_res;
            r_fin_sd <= r_sd[AW];
        end
    end

    assign o_valid = r_fin_v;
    assign o_incr  = r_fin;
    assign o_side  = r_fin_sd;

endmodule

`default_nettype wire

// ===== rtl/phase_field_isotropic_point_update_top.sv =====
// ----------------------------------------------------------------------------
// Phase-field isotropic point update
// Explicit Euler step for one interior grid point of a binary-alloy model.
// ----------------------------------------------------------------------------
// The block accepts one grid point per clock cycle while o_ready is high and
// returns one result beat per input beat, in order. Values are Q8.24; each
// point reaches the output register via eleven arithmetic stages with at most
// one multiplier per operand path each, a restoring divider that resolves one
// quotient bit per stage over 32 + FRAC_BITS stages plus entry and exit
// registers, and the output register. A two-entry output buffer lets the input
// keep flowing while a result waits. Configuration writes are never stalled.
`default_nettype none

module phase_field_isotropic_point_update_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire pfi_pkg::t_q         i_phase,
    input  wire pfi_pkg::t_q         i_potential,
    input  wire pfi_pkg::t_q         i_phase_laplacian,
    input  wire pfi_pkg::t_q         i_potential_laplacian,
    input  wire pfi_pkg::t_q         i_conc_east,
    input  wire pfi_pkg::t_q         i_conc_west,
    input  wire pfi_pkg::t_q         i_conc_north,
    input  wire pfi_pkg::t_q         i_conc_south,
    input  wire pfi_pkg::t_q         i_velocity_x,
    input  wire pfi_pkg::t_q         i_velocity_y,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pfi_pkg::t_q              o_phase_next,
    output pfi_pkg::t_q              o_potential_next,
    output logic                     o_saturated,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire pfi_pkg::t_cfg_idx   i_cfg_index,
    input  wire pfi_pkg::t_q         i_cfg_data
);
    import pfi_pkg::*;

    // Configuration registers.
    t_q r_ge, r_goe, r_itau, r_km1, r_mueq, r_dt, r_mob, r_isp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ge   <= CFG_ONE_RST;
            r_goe  <= CFG_ONE_RST;
            r_itau <= CFG_ONE_RST;
            r_km1  <= '0;
            r_mueq <= '0;
            r_dt   <= CFG_DT_RST;
            r_mob  <= CFG_ONE_RST;
            r_isp  <= CFG_ONE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GE_PRODUCT:     r_ge   <= i_cfg_data;
                CFG_G_OVER_E:       r_goe  <= i_cfg_data;
                CFG_INV_TAU_E:      r_itau <= i_cfg_data;
                CFG_K_MINUS_ONE:    r_km1  <= i_cfg_data;
                CFG_MU_EQUILIBRIUM: r_mueq <= i_cfg_data;
                CFG_TIME_STEP:      r_dt   <= i_cfg_data;
                CFG_MOBILITY:       r_mob  <= i_cfg_data;
                CFG_INV_SPACING:    r_isp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Pipeline advance: everything moves unless the output buffer is full.
    logic r_skid_v, r_out_v;
    logic en;
    assign en      = !r_skid_v;
    assign o_ready = en;

    // Stage valid bits.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11;

    // Stage registers.
    t_q   r_s1_p, r_s1_mu, r_s1_omp, r_s1_grad, r_s1_well, r_s1_om2p, r_s1_drv;
    t_q   r_s1_dx, r_s1_dy, r_s1_c, r_s1_pp, r_s1_t3, r_s1_lm, r_s1_vx, r_s1_vy;
    logic r_s1_s;
    t_q   r_s2_p, r_s2_mu, r_s2_omp, r_s2_grad, r_s2_om2p, r_s2_lm, r_s2_vx, r_s2_vy;
    t_q   r_s2_well, r_s2_drv, r_s2_dcx, r_s2_dcy, r_s2_c, r_s2_h;
    logic r_s2_s;
    t_q   r_s3_p, r_s3_mu, r_s3_omp, r_s3_grad, r_s3_om2p, r_s3_lm;
    t_q   r_s3_well, r_s3_drv, r_s3_ax, r_s3_ay, r_s3_c, r_s3_kh;
    logic r_s3_s;
    t_q   r_s4_p, r_s4_mu, r_s4_omp, r_s4_grad, r_s4_lm;
    t_q   r_s4_well, r_s4_drv, r_s4_adv, r_s4_c, r_s4_kai;
    logic r_s4_s;
    t_q   r_s5_p, r_s5_mu, r_s5_omp, r_s5_grad, r_s5_lm;
    t_q   r_s5_well, r_s5_drv, r_s5_adv, r_s5_c, r_s5_kai;
    logic r_s5_s;
    t_q   r_s6_p, r_s6_mu, r_s6_grad, r_s6_lm, r_s6_well, r_s6_drv, r_s6_adv;
    t_q   r_s6_c, r_s6_kai;
    logic r_s6_s;
    t_q   r_s7_p, r_s7_mu, r_s7_lm, r_s7_adv, r_s7_c, r_s7_kai, r_s7_sum;
    logic r_s7_s;
    t_q   r_s8_p, r_s8_mu, r_s8_lm, r_s8_adv, r_s8_c, r_s8_kai, r_s8_dpdt;
    logic r_s8_s;
    t_q   r_s9_p, r_s9_mu, r_s9_lm, r_s9_adv, r_s9_kai, r_s9_pinc, r_s9_coup;
    logic r_s9_s;
    t_q   r_s10_mu, r_s10_kai, r_s10_pnext, r_s10_dmu;
    logic r_s10_s;
    t_q   r_s11_mu, r_s11_kai, r_s11_pnext, r_s11_num;
    logic r_s11_s;

    // Next values of the stages.
    t_qval n_s1_omp, n_s1_grad, n_s1_well, n_s1_om2p, n_s1_drv, n_s1_dx, n_s1_dy;
    t_qval n_s1_c, n_s1_pp, n_s1_t3, n_s1_lm;
    t_qval n_s2_well, n_s2_drv, n_s2_dcx, n_s2_dcy, n_s2_c, n_s2_h;
    t_qval n_s3_well, n_s3_drv, n_s3_ax, n_s3_ay, n_s3_c, n_s3_kh;
    t_qval n_s4_well, n_s4_drv, n_s4_adv, n_s4_c, n_s4_kai;
    t_qval n_s5_drv, n_s6_drv, n_s7_sum, n_s8_dpdt;
    t_qval n_s9_pinc, n_s9_coup, n_s10_pnext, n_s10_dmu, n_s11_num;

    // Stage 1: terms formed directly from the input beat.
    always_comb begin
        n_s1_omp  = sat32(ONE_W - t_wide'(i_phase));
        n_s1_grad = qmul(r_ge, i_phase_laplacian);
        n_s1_well = sat32(64'sd18 * t_wide'(r_goe));
        n_s1_om2p = sat32(ONE_W - (t_wide'(i_phase) <<< 1));
        n_s1_drv  = sat32(t_wide'(i_potential) - t_wide'(r_mueq));
        n_s1_dx   = sat32((t_wide'(i_conc_east) - t_wide'(i_conc_west)) >>> 1);
        n_s1_dy   = sat32((t_wide'(i_conc_north) - t_wide'(i_conc_south)) >>> 1);
        n_s1_c    = qmul(r_km1, i_potential);
        n_s1_pp   = qmul(i_phase, i_phase);
        n_s1_t3   = sat32(THREE_W - (t_wide'(i_phase) <<< 1));
        n_s1_lm   = qmul(r_mob, i_potential_laplacian);
    end

    // Stages 2 to 4: double-well, drive, advection, coupling and susceptibility terms.
    always_comb begin
        n_s2_well = qmul(r_s1_well, r_s1_p);
        n_s2_drv  = qmul(r_s1_drv, r_km1);
        n_s2_dcx  = qmul(r_s1_dx, r_isp);
        n_s2_dcy  = qmul(r_s1_dy, r_isp);
        n_s2_c    = sat32(64'sd6 * t_wide'(r_s1_c));
        n_s2_h    = qmul(r_s1_pp, r_s1_t3);

        n_s3_well = qmul(r_s2_well, r_s2_omp);
        n_s3_drv  = qmul(r_s2_drv, r_s2_mu);
        n_s3_ax   = qmul(r_s2_vx, r_s2_dcx);
        n_s3_ay   = qmul(r_s2_vy, r_s2_dcy);
        n_s3_c    = qmul(r_s2_c, r_s2_p);
        n_s3_kh   = qmul(r_km1, r_s2_h);

        n_s4_well = qmul(r_s3_well, r_s3_om2p);
        n_s4_drv  = sat32(64'sd6 * t_wide'(r_s3_drv));
        n_s4_adv  = sat32(t_wide'(r_s3_ax) + t_wide'(r_s3_ay));
        n_s4_c    = qmul(r_s3_c, r_s3_omp);
        n_s4_kai  = sat32(ONE_W + t_wide'(r_s3_kh));
    end

    // Stages 5 to 11: finish the phase rate, then both increments.
    always_comb begin
        n_s5_drv    = qmul(r_s4_drv, r_s4_p);
        n_s6_drv    = qmul(r_s5_drv, r_s5_omp);
        n_s7_sum    = sat32(t_wide'(r_s6_grad) - t_wide'(r_s6_well) + t_wide'(r_s6_drv));
        n_s8_dpdt   = qmul(r_s7_sum, r_itau);
        n_s9_pinc   = qmul(r_dt, r_s8_dpdt);
        n_s9_coup   = qmul(r_s8_c, r_s8_dpdt);
        n_s10_pnext = sat32(t_wide'(r_s9_p) + t_wide'(r_s9_pinc));
        n_s10_dmu   = sat32(t_wide'(r_s9_lm) - t_wide'(r_s9_adv) - t_wide'(r_s9_coup));
        n_s11_num   = qmul(r_dt, r_s10_dmu);
    end

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else if (en) begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_p    <= i_phase;
            r_s1_mu   <= i_potential;
            r_s1_vx   <= i_velocity_x;
            r_s1_vy   <= i_velocity_y;
            r_s1_omp  <= n_s1_omp.v;
            r_s1_grad <= n_s1_grad.v;
            r_s1_well <= n_s1_well.v;
            r_s1_om2p <= n_s1_om2p.v;
            r_s1_drv  <= n_s1_drv.v;
            r_s1_dx   <= n_s1_dx.v;
            r_s1_dy   <= n_s1_dy.v;
            r_s1_c    <= n_s1_c.v;
            r_s1_pp   <= n_s1_pp.v;
            r_s1_t3   <= n_s1_t3.v;
            r_s1_lm   <= n_s1_lm.v;
            r_s1_s    <= n_s1_omp.s | n_s1_grad.s | n_s1_well.s | n_s1_om2p.s
                       | n_s1_drv.s | n_s1_dx.s | n_s1_dy.s | n_s1_c.s
                       | n_s1_pp.s | n_s1_t3.s | n_s1_lm.s;

            r_s2_p    <= r_s1_p;
            r_s2_mu   <= r_s1_mu;
            r_s2_omp  <= r_s1_omp;
            r_s2_grad <= r_s1_grad;
            r_s2_om2p <= r_s1_om2p;
            r_s2_lm   <= r_s1_lm;
            r_s2_vx   <= r_s1_vx;
            r_s2_vy   <= r_s1_vy;
            r_s2_well <= n_s2_well.v;
            r_s2_drv  <= n_s2_drv.v;
            r_s2_dcx  <= n_s2_dcx.v;
            r_s2_dcy  <= n_s2_dcy.v;
            r_s2_c    <= n_s2_c.v;
            r_s2_h    <= n_s2_h.v;
            r_s2_s    <= r_s1_s | n_s2_well.s | n_s2_drv.s | n_s2_dcx.s | n_s2_dcy.s
                       | n_s2_c.s | n_s2_h.s;

            r_s3_p    <= r_s2_p;
            r_s3_mu   <= r_s2_mu;
            r_s3_omp  <= r_s2_omp;
            r_s3_grad <= r_s2_grad;
            r_s3_om2p <= r_s2_om2p;
            r_s3_lm   <= r_s2_lm;
            r_s3_well <= n_s3_well.v;
            r_s3_drv  <= n_s3_drv.v;
            r_s3_ax   <= n_s3_ax.v;
            r_s3_ay   <= n_s3_ay.v;
            r_s3_c    <= n_s3_c.v;
            r_s3_kh   <= n_s3_kh.v;
            r_s3_s    <= r_s2_s | n_s3_well.s | n_s3_drv.s | n_s3_ax.s | n_s3_ay.s
                       | n_s3_c.s | n_s3_kh.s;

            r_s4_p    <= r_s3_p;
            r_s4_mu   <= r_s3_mu;
            r_s4_omp  <= r_s3_omp;
            r_s4_grad <= r_s3_grad;
            r_s4_lm   <= r_s3_lm;
            r_s4_well <= n_s4_well.v;
            r_s4_drv  <= n_s4_drv.v;
            r_s4_adv  <= n_s4_adv.v;
            r_s4_c    <= n_s4_c.v;
            r_s4_kai  <= n_s4_kai.v;
            r_s4_s    <= r_s3_s | n_s4_well.s | n_s4_drv.s | n_s4_adv.s | n_s4_c.s
                       | n_s4_kai.s;

            r_s5_p    <= r_s4_p;
            r_s5_mu   <= r_s4_mu;
            r_s5_omp  <= r_s4_omp;
            r_s5_grad <= r_s4_grad;
            r_s5_lm   <= r_s4_lm;
            r_s5_well <= r_s4_well;
            r_s5_adv  <= r_s4_adv;
            r_s5_c    <= r_s4_c;
            r_s5_kai  <= r_s4_kai;
            r_s5_drv  <= n_s5_drv.v;
            r_s5_s    <= r_s4_s | n_s5_drv.s;

            r_s6_p    <= r_s5_p;
            r_s6_mu   <= r_s5_mu;
            r_s6_grad <= r_s5_grad;
            r_s6_lm   <= r_s5_lm;
            r_s6_well <= r_s5_well;
            r_s6_adv  <= r_s5_adv;
            r_s6_c    <= r_s5_c;
            r_s6_kai  <= r_s5_kai;
            r_s6_drv  <= n_s6_drv.v;
            r_s6_s    <= r_s5_s | n_s6_drv.s;

            r_s7_p    <= r_s6_p;
            r_s7_mu   <= r_s6_mu;
            r_s7_lm   <= r_s6_lm;
            r_s7_adv  <= r_s6_adv;
            r_s7_c    <= r_s6_c;
            r_s7_kai  <= r_s6_kai;
            r_s7_sum  <= n_s7_sum.v;
            r_s7_s    <= r_s6_s | n_s7_sum.s;

            r_s8_p    <= r_s7_p;
            r_s8_mu   <= r_s7_mu;
            r_s8_lm   <= r_s7_lm;
            r_s8_adv  <= r_s7_adv;
            r_s8_c    <= r_s7_c;
            r_s8_kai  <= r_s7_kai;
            r_s8_dpdt <= n_s8_dpdt.v;
            r_s8_s    <= r_s7_s | n_s8_dpdt.s;

            r_s9_p    <= r_s8_p;
            r_s9_mu   <= r_s8_mu;
            r_s9_lm   <= r_s8_lm;
            r_s9_adv  <= r_s8_adv;
            r_s9_kai  <= r_s8_kai;
            r_s9_pinc <= n_s9_pinc.v;
            r_s9_coup <= n_s9_coup.v;
            r_s9_s    <= r_s8_s | n_s9_pinc.s | n_s9_coup.s;

            r_s10_mu    <= r_s9_mu;
            r_s10_kai   <= r_s9_kai;
            r_s10_pnext <= n_s10_pnext.v;
            r_s10_dmu   <= n_s10_dmu.v;
            r_s10_s     <= r_s9_s | n_s10_pnext.s | n_s10_dmu.s;

            r_s11_mu    <= r_s10_mu;
            r_s11_kai   <= r_s10_kai;
            r_s11_pnext <= r_s10_pnext;
            r_s11_num   <= n_s11_num.v;
            r_s11_s     <= r_s10_s | n_s11_num.s;
        end
    end

    // Potential increment divided by the susceptibility.
    t_side div_side_in;
    t_side div_side;
    t_qval div_incr;
    logic  div_v;

    always_comb begin
        div_side_in.sat   = r_s11_s;
        div_side_in.pnext = r_s11_pnext;
        div_side_in.mu    = r_s11_mu;
    end

    pfi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v11),
        .i_num   (r_s11_num),
        .i_den   (r_s11_kai),
        .i_side  (div_side_in),
        .o_valid (div_v),
        .o_incr  (div_incr),
        .o_side  (div_side)
    );

    // Final potential and flag.
    t_qval n_munext;
    logic  n_fin_sat;
    always_comb begin
        n_munext  = sat32(t_wide'(div_side.mu) + t_wide'(div_incr.v));
        n_fin_sat = div_side.sat | div_incr.s | n_munext.s;
    end

    // Output register with a skid entry behind it.
    t_q   r_out_p, r_out_mu, r_skid_p, r_skid_mu;
    logic r_out_s, r_skid_s;
    logic take;
    assign take = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            priority if (r_skid_v) begin
                if (take) begin
                    r_skid_v <= 1'b0;
                end
            end else if (div_v) begin
                if (!r_out_v || take) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (take) begin
                r_out_v <= 1'b0;
            end else begin
                // Nothing arrives and nothing leaves.
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_skid_v) begin
            if (take) begin
                r_out_p  <= r_skid_p;
                r_out_mu <= r_skid_mu;
                r_out_s  <= r_skid_s;
            end
        end else if (div_v) begin
            if (!r_out_v || take) begin
                r_out_p  <= div_side.pnext;
                r_out_mu <= n_munext.v;
                r_out_s  <= n_fin_sat;
            end else begin
                r_skid_p  <= div_side.pnext;
                r_skid_mu <= n_munext.v;
                r_skid_s  <= n_fin_sat;
            end
        end else begin
            // The buffered beats keep their values.
        end
    end

    assign o_valid          = r_out_v;
    assign o_phase_next     = r_out_p;
    assign o_potential_next = r_out_mu;
    assign o_saturated      = r_out_s;

    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry full while output register empty");

    // Draining the skid entry refills the output register and frees the skid.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_ready) |=> (r_out_v && !r_skid_v))
        else $error("skid entry not moved to output register");

    // While the skid entry holds a beat, no new input beat is taken.
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !o_ready)
        else $error("input accepted while output buffer full");

endmodule

`default_nettype wire
